>>> design/sle_pkg.sv
// sle_pkg: shared types and constants for the serial line editor.
// No dependencies; used by the controller, datapath, top level and checker.
package sle_pkg;

  localparam int unsigned FILL_W = 6;

  localparam logic [FILL_W-1:0] LIMIT_RESET = 6'd32;

  // result kinds carried on out_tuser
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // configuration register byte addresses
  localparam logic [2:0] REG_LINE_LIMIT = 3'd0;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ECHO = 6'b000010,
    ST_CR   = 6'b000100,
    ST_LF   = 6'b001000,
    ST_DUMP = 6'b010000,
    ST_END  = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    SEL_ECHO = 3'd0,
    SEL_CR   = 3'd1,
    SEL_LF   = 3'd2,
    SEL_CHAR = 3'd3,
    SEL_END  = 3'd4
  } out_sel_t;

  typedef struct packed {
    logic     take;      // input word accepted this cycle
    logic     load;      // load the output register
    out_sel_t sel;
    logic     last;
    logic     ptr_step;  // advance the dump pointer
    logic     fill_clr;
  } cmd_t;

  typedef struct packed {
    logic eol;        // CR or LF received
    logic bs_ok;      // backspace on a non-empty line
    logic store_ok;   // printable byte with room left
    logic fill_zero;
    logic dump_done;  // pointer sits on the last kept character
    logic slot_free;  // output register can take a word
  } status_t;

endpackage

>>> design/sle_ctrl.sv
// sle_ctrl: one-hot sequencer of the serial line editor.
// Depends on sle_pkg; drives commands to sle_dp and reads its status.
module sle_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  sle_pkg::status_t status,
  output sle_pkg::cmd_t    cmd
);

  sle_pkg::state_t state_r, state_nxt;

  assign in_tready = (state_r == sle_pkg::ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.sel      = sle_pkg::SEL_ECHO;
    unique case (state_r)
      sle_pkg::ST_IDLE: begin
        cmd.take = in_tvalid;
        if (in_tvalid) begin
          priority if (status.eol) begin
            state_nxt = sle_pkg::ST_CR;
          end else if (status.bs_ok || status.store_ok) begin
            state_nxt = sle_pkg::ST_ECHO;
          end else begin
            state_nxt = sle_pkg::ST_IDLE;
          end
        end
      end
      sle_pkg::ST_ECHO: begin
        cmd.sel  = sle_pkg::SEL_ECHO;
        cmd.last = 1'b1;
        if (status.slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = sle_pkg::ST_IDLE;
        end
      end
      sle_pkg::ST_CR: begin
        cmd.sel = sle_pkg::SEL_CR;
        if (status.slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = sle_pkg::ST_LF;
        end
      end
      sle_pkg::ST_LF: begin
        cmd.sel = sle_pkg::SEL_LF;
        if (status.slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = status.fill_zero ? sle_pkg::ST_END : sle_pkg::ST_DUMP;
        end
      end
      sle_pkg::ST_DUMP: begin
        cmd.sel = sle_pkg::SEL_CHAR;
        if (status.slot_free) begin
          cmd.load     = 1'b1;
          cmd.ptr_step = 1'b1;
          if (status.dump_done) begin
            state_nxt = sle_pkg::ST_END;
          end
        end
      end
      sle_pkg::ST_END: begin
        cmd.sel  = sle_pkg::SEL_END;
        cmd.last = 1'b1;
        if (status.slot_free) begin
          cmd.load     = 1'b1;
          cmd.fill_clr = 1'b1;
          state_nxt    = sle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sle_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sle_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/sle_dp.sv
// sle_dp: line store, fill count, dump pointer, limit register and output register.
// Depends on sle_pkg; commanded by sle_ctrl.
module sle_dp #(
  parameter int unsigned LINE_MAX = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  input  sle_pkg::cmd_t    cmd,
  output sle_pkg::status_t status
);

  localparam int unsigned FW    = sle_pkg::FILL_W;
  localparam int unsigned IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam logic [FW-1:0] LMAX = FW'(LINE_MAX);

  logic [7:0]    mem [LINE_MAX];
  logic [7:0]    rd_data_r;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] ptr_r, ptr_nxt;
  logic [FW-1:0] limit_r;
  logic [FW-1:0] limit_eff;
  logic [FW-1:0] rd_addr;
  logic [7:0]    byte_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic [1:0]    out_kind_r;
  logic          out_last_r;
  logic [7:0]    sel_byte;
  logic [1:0]    sel_kind;
  logic          is_eol, is_bs, is_prt, cfg_wr;

  // decode of the incoming byte
  assign is_eol = (in_tdata == sle_pkg::CH_CR) || (in_tdata == sle_pkg::CH_LF);
  assign is_bs  = (in_tdata == sle_pkg::CH_BS) || (in_tdata == sle_pkg::CH_DEL);
  assign is_prt = (in_tdata >= sle_pkg::CH_SPACE) && (in_tdata < sle_pkg::CH_DEL);

  assign limit_eff = (limit_r > LMAX) ? LMAX : limit_r;

  assign status.eol       = is_eol;
  assign status.bs_ok     = is_bs && (fill_r != '0);
  assign status.store_ok  = is_prt && (fill_r < limit_eff) && (fill_r < LMAX);
  assign status.fill_zero = (fill_r == '0);
  assign status.dump_done = ((ptr_r + FW'(1)) == fill_r);
  assign status.slot_free = !out_valid_r || out_tready;

  // config register
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == sle_pkg::REG_LINE_LIMIT[2]);
  assign cfg_prdata = (cfg_paddr[2] == sle_pkg::REG_LINE_LIMIT[2]) ?
                      {{(32-FW){1'b0}}, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= sle_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_r <= cfg_pwdata[FW-1:0];
    end
  end

  // fill count and dump pointer
  always_comb begin
    fill_nxt = fill_r;
    ptr_nxt  = ptr_r;
    if (cmd.take) begin
      ptr_nxt = '0;
      if (status.bs_ok) begin
        fill_nxt = fill_r - FW'(1);
      end else if (status.store_ok) begin
        fill_nxt = fill_r + FW'(1);
      end
    end
    if (cmd.ptr_step) begin
      ptr_nxt = ptr_r + FW'(1);
    end
    if (cmd.fill_clr) begin
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ptr_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      ptr_r  <= ptr_nxt;
    end
  end

  // line store: written while idle, read one word ahead during the dump
  assign rd_addr = ptr_nxt;

  always_ff @(posedge clk) begin
    if (cmd.take && status.store_ok) begin
      mem[fill_r[IDX_W-1:0]] <= in_tdata;
    end
    rd_data_r <= mem[rd_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_r <= in_tdata;
    end
  end

  always_comb begin
    unique case (cmd.sel)
      sle_pkg::SEL_ECHO: begin
        sel_kind = sle_pkg::KIND_ECHO;
        sel_byte = byte_r;
      end
      sle_pkg::SEL_CR: begin
        sel_kind = sle_pkg::KIND_ECHO;
        sel_byte = sle_pkg::CH_CR;
      end
      sle_pkg::SEL_LF: begin
        sel_kind = sle_pkg::KIND_ECHO;
        sel_byte = sle_pkg::CH_LF;
      end
      sle_pkg::SEL_CHAR: begin
        sel_kind = sle_pkg::KIND_CHAR;
        sel_byte = rd_data_r;
      end
      sle_pkg::SEL_END: begin
        sel_kind = sle_pkg::KIND_END;
        sel_byte = 8'd0;
      end
      default: begin
        sel_kind = sle_pkg::KIND_END;
        sel_byte = 8'd0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_byte_r <= sel_byte;
      out_kind_r <= sel_kind;
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

>>> design/serial_line_editor.sv
// serial_line_editor: top level, joins the sequencer and the datapath.
// Depends on sle_pkg, sle_ctrl and sle_dp.
//
//   channel  | direction | payload
//   ---------+-----------+----------------------------------------------
//   in_      | slave     | tdata = rx_byte
//   out_     | master    | tdata = out_byte, tuser = out_kind, tlast = run_last
//   cfg_     | APB slave | line_limit at byte address 0
//
// An ignored byte leaves the sequencer in ST_IDLE; an echo goes through ST_ECHO.
// An end of line sends CR, LF, one word per kept character
// (read from the line store one word ahead), then the end marker.
// Output stalls hold the sequencer in place; the output register lets the
// next byte be taken while the last word still waits. Reset is synchronous.
module serial_line_editor #(
  parameter int unsigned LINE_MAX = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic [1:0]  out_tuser,   // [1:0] out_kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  sle_pkg::cmd_t    cmd;
  sle_pkg::status_t status;

  assign cfg_pready = 1'b1;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sle_dp #(
    .LINE_MAX (LINE_MAX)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

>>> design/sle_checker.sv
// sle_checker: port-level assertions for serial_line_editor, bound to the top.
// Depends on sle_pkg.
module sle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output word changed");

  a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == sle_pkg::KIND_END) |-> (out_tdata == 8'd0) && out_tlast)
    else $error("end marker malformed");

  a_char_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == sle_pkg::KIND_CHAR) |-> !out_tlast)
    else $error("line character marked last");

  // an end of line always produces words, so input stays blocked a while
  a_eol_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
      ((in_tdata == sle_pkg::CH_CR) || (in_tdata == sle_pkg::CH_LF)) |=> !in_tready)
    else $error("input taken during end-of-line dump");

endmodule

bind serial_line_editor sle_checker u_sle_checker (.*);

>>> verif/tb_serial_line_editor.sv
// tb_serial_line_editor: self-checking testbench for the serial line editor.
// Depends on sle_pkg and serial_line_editor; predicts every result word and
// checks it on the out_ stream while both streams idle and stall at random.
module tb_serial_line_editor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_MAX   = 32;
  localparam int unsigned SETTLE     = 48;    // longest end of line plus margin
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state
  logic [7:0]  line_chars [LINE_MAX];
  int unsigned char_count = 0;
  logic [5:0]  limit_reg = sle_pkg::LIMIT_RESET;
  word_t       pending_words[$];

  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;

  serial_line_editor #(.LINE_MAX(LINE_MAX)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 32);
  end

  function automatic bit is_ignored(input logic [7:0] b);
    return !(b == sle_pkg::CH_CR || b == sle_pkg::CH_LF || b == sle_pkg::CH_BS ||
             b == sle_pkg::CH_DEL || (b >= sle_pkg::CH_SPACE && b < sle_pkg::CH_DEL));
  endfunction

  function automatic void push_word(input logic [1:0] kind, input logic [7:0] data,
                                    input logic last);
    word_t w;
    w.kind = kind;
    w.data = data;
    w.last = last;
    pending_words.push_back(w);
  endfunction

  // update the predicted line for one accepted byte and queue its words
  function automatic void edit_line(input logic [7:0] b);
    int unsigned room;
    room = (limit_reg > LINE_MAX) ? LINE_MAX : limit_reg;
    if (b == sle_pkg::CH_CR || b == sle_pkg::CH_LF) begin
      push_word(sle_pkg::KIND_ECHO, sle_pkg::CH_CR, 1'b0);
      push_word(sle_pkg::KIND_ECHO, sle_pkg::CH_LF, 1'b0);
      for (int unsigned i = 0; i < char_count; i++)
        push_word(sle_pkg::KIND_CHAR, line_chars[i], 1'b0);
      push_word(sle_pkg::KIND_END, 8'h00, 1'b1);
      char_count = 0;
    end else if (b == sle_pkg::CH_BS || b == sle_pkg::CH_DEL) begin
      if (char_count > 0) begin
        char_count--;
        push_word(sle_pkg::KIND_ECHO, b, 1'b1);
      end
    end else if (!is_ignored(b) && char_count < room) begin
      line_chars[char_count] = b;
      char_count++;
      push_word(sle_pkg::KIND_ECHO, b, 1'b1);
    end
  endfunction

  always @(posedge clk) begin : check_words
    word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: kind %0d byte %02h last %0d", out_tuser, out_tdata,
               out_tlast);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (out_tuser !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, out_tuser);
          errors++;
        end
        if (out_tdata !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_tdata);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("run_last: expected %0d, got %0d", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // timeout: no word moved on any channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!no_idle && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    edit_line(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i]);
  endtask

  // wait until every word is out and an ignored byte can no longer be in flight
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_line_limit(input logic [5:0] v);
    drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= sle_pkg::REG_LINE_LIMIT;
    cfg_pwdata  <= {26'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    limit_reg = v;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[5:0] !== v) begin
      $error("line_limit: expected %0d, got %0d", v, cfg_prdata[5:0]);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // ignored bytes, backspace on an empty line, empty line ended, echo and erase
  task automatic test_basic_edit;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h1F);
    send_byte(8'h80);
    send_byte(sle_pkg::CH_BS);
    send_byte(sle_pkg::CH_DEL);
    send_byte(sle_pkg::CH_CR);
    send_text(" A~");
    send_byte(sle_pkg::CH_BS);
    send_byte(sle_pkg::CH_DEL);
    send_byte(sle_pkg::CH_LF);
  endtask

  // full line drops printable bytes silently; zero limit keeps nothing
  task automatic test_line_full;
    set_line_limit(6'd3);
    send_text("xyzqr");
    send_byte(sle_pkg::CH_CR);
    set_line_limit(6'd0);
    send_byte("a");
    send_byte(sle_pkg::CH_BS);
    send_byte(sle_pkg::CH_CR);
  endtask

  // limit lowered under the fill: kept characters stay, new ones are dropped until there is room
  task automatic test_limit_lowered;
    set_line_limit(6'd32);
    send_text("abcd");
    set_line_limit(6'd2);
    send_byte("g");
    repeat (3) send_byte(sle_pkg::CH_BS);
    send_text("ij");
    send_byte(sle_pkg::CH_CR);
  endtask

  // limit above the store size saturates at the store size
  task automatic test_long_line;
    set_line_limit(6'd63);
    repeat (LINE_MAX + 4) send_byte(8'($urandom_range(8'h20, 8'h7E)));
    send_byte(sle_pkg::CH_LF);
  endtask

  // mostly lines with random content, some edits and some line noise
  task automatic test_random_lines(input logic [5:0] lim, input int unsigned count);
    int unsigned sent;
    int unsigned roll;
    logic [7:0]  b;
    set_line_limit(lim);
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 68)
        b = 8'($urandom_range(8'h20, 8'h7E));
      else if (roll < 78)
        b = $urandom_range(1) ? sle_pkg::CH_BS : sle_pkg::CH_DEL;
      else if (roll < 86)
        b = $urandom_range(1) ? sle_pkg::CH_CR : sle_pkg::CH_LF;
      else
        b = 8'($urandom_range(255));
      send_byte(b);
      if (!is_ignored(b)) sent++;
    end
    send_byte(sle_pkg::CH_CR);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_edit();
    test_line_full();
    test_limit_lowered();
    test_long_line();
    test_random_lines(6'd32, 12);
    test_random_lines(6'd5, 12);
    no_idle = 1'b1;
    test_random_lines(6'd63, 12);
    no_idle = 1'b0;
    test_random_lines(6'd1, 12);
    test_random_lines(6'd20, 12);
    test_random_lines(6'($urandom_range(63)), 12);
    drain();
    if (errors == 0 && pending_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> serial_line_editor.f
design/sle_pkg.sv
design/sle_ctrl.sv
design/sle_dp.sv
design/serial_line_editor.sv
design/sle_checker.sv
verif/tb_serial_line_editor.sv
